// ===== design/i2da_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes and arithmetic constants shared by the design and its checker.
// No dependencies.
package i2da_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W = 7;
   localparam int DIGIT_W = 4;
   localparam int MAX_DIGITS = 10;
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

   // Quotient by ten is (x * RECIP_TEN) >> QUOT_SHIFT, exact for every 32-bit x.
   localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int QUOT_SHIFT = 35;
   localparam int QUOT_W = 2 * VALUE_W - QUOT_SHIFT;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

endpackage

// ===== design/int_to_decimal_ascii.sv =====
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on i2da_pkg for character codes and the reciprocal-of-ten constant.
//
//  channel  | ports                            | handshake
//  ---------+----------------------------------+-------------------------------------
//  request  | req_value[31:0] signed           | transfer when start high, busy low
//  response | rsp_ch[6:0], rsp_last            | transfer on every cycle rsp_strobe high
//
// A value runs the digit loop once per decimal digit, then emits its text, with a leading
// minus sign when negative. Each pass of the loop uses the one shared 32x32 multiplier
// for the product step (ST_MUL), then takes the remainder step (ST_DIV).
// Reset is synchronous and active high; it returns the sequencer to idle and drops busy.
// The receiver cannot stall: characters leave one per cycle once emission begins.
module int_to_decimal_ascii
   import i2da_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic        [CHAR_W-1:0]  rsp_ch,
   output logic                      rsp_last
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [QUOT_W-1:0]      quot_ff, quot_in;
   logic [DIGIT_CNT_W-1:0] ndig_ff, ndig_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic [DIGIT_W-1:0]     digit_ff [MAX_DIGITS];

   logic [2*VALUE_W-1:0]   product;
   logic [DIGIT_W-1:0]     quot_x10_lo;
   logic [DIGIT_W-1:0]     rem_digit;
   logic                   digit_we;

   // The shared unit: magnitude times the reciprocal of ten. Its upper bits are the
   // quotient, which is registered before the remainder step uses it.
   assign product = mag_ff * RECIP_TEN;

   // The remainder is below ten, so only the low four bits of mag - 10*q matter.
   assign quot_x10_lo = {quot_ff[0], 3'b000} + {quot_ff[2:0], 1'b0};
   assign rem_digit   = mag_ff[DIGIT_W-1:0] - quot_x10_lo;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      quot_in  = quot_ff;
      ndig_in  = ndig_ff;
      idx_in   = idx_ff;
      digit_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = req_value[VALUE_W-1];
               // The most negative value negates to itself, which as unsigned is
               // exactly its magnitude.
               mag_in   = req_value[VALUE_W-1] ? (~req_value + 1'b1) : req_value;
               ndig_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            quot_in  = product[2*VALUE_W-1:QUOT_SHIFT];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Digits are collected least significant first and read back in reverse.
            digit_we = 1'b1;
            mag_in   = {{(VALUE_W-QUOT_W){1'b0}}, quot_ff};
            ndig_in  = ndig_ff + 1'b1;
            idx_in   = ndig_ff[DIGIT_IDX_W-1:0];
            if (quot_ff != '0) begin
               state_in = ST_MUL;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      ndig_ff <= ndig_in;
      idx_ff  <= idx_in;
   end

   // Digit buffer, written once per remainder step.
   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_ff[ndig_ff[DIGIT_IDX_W-1:0]] <= rem_digit;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_ch     = (state_ff == ST_SIGN) ? CHAR_MINUS
                     : (CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit_ff[idx_ff]});
   assign rsp_last   = (state_ff == ST_EMIT) && (idx_ff == '0);

endmodule

// ===== design/i2da_check.sv =====
// Port-level checker for the integer to decimal ASCII converter, with its bind.
// Depends on i2da_pkg for the character codes.
module i2da_check
   import i2da_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      rsp_strobe,
   input logic        [CHAR_W-1:0]  rsp_ch,
   input logic                      rsp_last
);

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // Characters of one text leave in consecutive cycles until the last one.
   a_text_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a character sequence");

   // After the last character the block is free again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy)
      else $error("busy still high after last character");

   // The sign never ends a text, and every character is a sign or a digit.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_ch == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked as last character");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ch == CHAR_MINUS) || ((rsp_ch >= CHAR_ZERO) && (rsp_ch <= CHAR_NINE)))
      else $error("character is neither a digit nor a minus sign");

endmodule

bind int_to_decimal_ascii i2da_check u_i2da_check (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for int_to_decimal_ascii, the signed 32-bit to decimal text converter.
// Depends on i2da_pkg for widths and character codes; needs only the design files to build.
module tb_top;
   import i2da_pkg::*;

   localparam int RESET_CYCLES = 11;
   // The settle time covers a ten-digit negative value, the longest text, with margin.
   localparam int SETTLE_CYCLES = 64;
   // No transfer in either direction for this long means the design has hung.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [VALUE_W-1:0] DEC_BASE = 10;

   // One character of expected text, as the response channel should present it.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_strobe;
   logic        [CHAR_W-1:0]  rsp_ch;
   logic                      rsp_last;

   // Characters predicted for accepted values, oldest first.
   text_char_type pending_chars[$];
   int            fail_count;
   // When clear, values are offered back to back with start held high.
   bit            idling_on;

   int_to_decimal_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_ch     (rsp_ch),
      .rsp_last   (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string msg);
      fail_count++;
      $display("%0t: %s", $time, msg);
   endtask

   // Expected text of one value: an optional minus sign, then the digits of the unsigned
   // magnitude, most significant first. The most negative value works out because its
   // two's complement negation, read as unsigned, is exactly 2147483648.
   function automatic void queue_decimal_text(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      int                 ndig;
      mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
      ndig = 0;
      // Zero still yields one digit, since the loop body runs at least once.
      do begin
         digits[ndig] = DIGIT_W'(mag % DEC_BASE);
         mag = mag / DEC_BASE;
         ndig++;
      end while (mag != 0 && ndig < MAX_DIGITS);
      if (value[VALUE_W-1]) begin
         pending_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
      end
      for (int k = ndig - 1; k >= 0; k--) begin
         pending_chars.push_back('{ch: CHAR_ZERO + CHAR_W'(digits[k]), last: (k == 0)});
      end
   endfunction

   // Offers one value and returns at the clock edge where it is accepted. Start is left high
   // on return so that a following value can go out without a dead cycle; whoever acts next
   // in the same time step either replaces the value or lowers start, never both.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      if (idling_on && $urandom_range(2) == 0) begin
         gap = $urandom_range(7, 1);
         start <= 1'b0;
         // Let the previous value run out so the gap lands while the block is idle.
         do @(posedge clock); while (busy !== 1'b0);
         repeat (gap - 1) @(posedge clock);
      end
      start <= 1'b1;
      req_value <= value;
      // The transfer happens at the first edge that sees start high and busy low.
      do @(posedge clock); while (busy !== 1'b0);
      queue_decimal_text(value);
   endtask

   // Ends a group of values: stops offering and waits for every predicted character.
   task automatic drain_text();
      start <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // A random value with the given number of decimal digits in its magnitude and a random sign.
   function automatic logic [VALUE_W-1:0] value_with_digits(input int ndig);
      longint unsigned lo;
      longint unsigned hi;
      logic [VALUE_W-1:0] mag;
      lo = 1;
      repeat (ndig - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (ndig == 1) lo = 0;
      if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
      mag = $urandom_range(hi[31:0], lo[31:0]);
      return ($urandom_range(1) != 0) ? -mag : mag;
   endfunction

   // Edge values: zero, single digits, the ends of the signed range (including the most
   // negative value, which has no positive counterpart), powers of ten and their neighbors,
   // and alternating bit patterns so every input bit is seen at both levels.
   task automatic test_extremes();
      logic [VALUE_W-1:0] corner_values [$];
      corner_values = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                        32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                        32'd999999999, 32'd1000000000, -32'sd1000000000,
                        32'd1234567890, -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'd7};
      idling_on = 1'b1;
      foreach (corner_values[i]) send_value(corner_values[i]);
      drain_text();
   endtask

   // Magnitudes spread evenly over digit counts, so short and long texts both get exercised.
   // Idling switches on and off in stretches.
   task automatic test_random_lengths();
      for (int i = 0; i < 110; i++) begin
         if (i % 16 == 0) idling_on = ($urandom_range(3) != 0);
         send_value(value_with_digits($urandom_range(10, 1)));
      end
      drain_text();
   endtask

   // Raw 32-bit words; these are mostly ten-digit values of either sign.
   task automatic test_random_words();
      for (int i = 0; i < 50; i++) begin
         if (i % 16 == 0) idling_on = ($urandom_range(3) != 0);
         send_value($urandom);
      end
      drain_text();
   endtask

   // Final stretch with start held high throughout: each value must be taken as soon as
   // the previous one is done.
   task automatic test_back_to_back();
      idling_on = 1'b0;
      for (int i = 0; i < 30; i++) begin
         send_value(value_with_digits($urandom_range(10, 1)));
      end
      drain_text();
   endtask

   // Every character transfer is compared with the oldest prediction, field by field.
   always @(posedge clock) begin : check_chars
      text_char_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_chars.size() == 0) begin
            flag_error($sformatf("unexpected character: expected none, got ch=%h last=%b",
                                 rsp_ch, rsp_last));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_ch !== want.ch) begin
               flag_error($sformatf("ch mismatch: expected %h, got %h", want.ch, rsp_ch));
            end
            if (rsp_last !== want.last) begin
               flag_error($sformatf("last mismatch: expected %b, got %b",
                                    want.last, rsp_last));
            end
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      idling_on = 1'b1;
      fail_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_random_lengths();
      test_random_words();
      test_back_to_back();

      // Anything still coming out now had no value behind it.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_chars.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
